### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/rdf_pkg.sv
// Types, codes and constants shared by the record deframer modules.
package rdf_pkg;

  localparam int MaxLongRecordDef = 1048576;
  localparam int FifoDepthDef     = 4;
  localparam int LenW             = 21;

  localparam logic [7:0]      CharCr  = 8'h0d;
  localparam logic [7:0]      CharLf  = 8'h0a;
  localparam logic [LenW-1:0] LineSat = '1;

  typedef enum logic [1:0] {
    ModeHdr16 = 2'd0,
    ModeHdr32 = 2'd1,
    ModeText  = 2'd2,
    ModePass  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindEnd     = 2'd1,
    KindError   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RegMode   = 2'd0,
    RegMaxLen = 2'd1,
    RegPolicy = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] max_len;
    logic        policy;
  } cfg_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    logic [LenW-1:0] len;
  } res_t;

  // One classified byte: one or two results for the back end.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } op_t;

  function automatic res_t mk_res(kind_e k, logic [7:0] d, logic [LenW-1:0] l);
    res_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    return r;
  endfunction

endpackage

### hw/rtl/rdf_front.sv
// Front end: accepts bytes, tracks framing state and classifies each byte.
module rdf_front #(
  parameter int MaxLongRecord = rdf_pkg::MaxLongRecordDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rdf_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output logic          push_o,
  output rdf_pkg::op_t  op_o
);
  import rdf_pkg::*;

  localparam int RemBits = $clog2(64'(MaxLongRecord) + 64'd1);
  localparam int RemW    = (RemBits > 16) ? RemBits : 16;
  localparam logic [31:0] MaxLong32 = 32'(MaxLongRecord);

  logic [2:0]      hc_q, hc_d, hc_nx, need;
  logic [31:0]     acc_q, acc_d, acc_nx, len32;
  logic [RemW-1:0] rem_q, rem_d;
  logic [LenW-1:0] lc_q, lc_d, lc_w;
  logic            pcr_q, pcr_d;
  logic            err_q, err_d;
  logic            wide, too_long;
  logic [1:0]      cnt;
  res_t            slot [2];

  assign wide = (cfg_i.mode == ModeHdr32);
  assign need = wide ? 3'd4 : 3'd2;

  always_comb begin
    hc_d     = hc_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    lc_d     = lc_q;
    pcr_d    = pcr_q;
    err_d    = err_q;
    hc_nx    = hc_q + 3'd1;
    acc_nx   = {acc_q[23:0], rx_byte_i};
    len32    = wide ? acc_nx : {16'h0000, acc_nx[15:0]};
    too_long = '0;
    lc_w     = lc_q;
    cnt      = 2'd0;
    slot[0]  = '0;
    slot[1]  = '0;
    if (!err_q) begin
      case (cfg_i.mode)
        ModeHdr16, ModeHdr32: begin
          if (rem_q != '0) begin
            slot[cnt[0]] = mk_res(KindPayload, rx_byte_i, '0);
            cnt = cnt + 2'd1;
            rem_d = rem_q - 1'b1;
            if (rem_q == RemW'(1)) begin
              slot[cnt[0]] = mk_res(KindEnd, '0, acc_q[LenW-1:0]);
              cnt = cnt + 2'd1;
            end
          end else begin
            acc_d = acc_nx;
            if (hc_nx < need) begin
              hc_d = hc_nx;
            end else begin
              hc_d = '0;
              if (wide) begin
                too_long = (acc_nx > MaxLong32);
              end else begin
                too_long = (cfg_i.max_len != '0) && (acc_nx[15:0] > cfg_i.max_len) &&
                           !cfg_i.policy;
              end
              if (too_long) begin
                err_d = 1'b1;
                slot[cnt[0]] = mk_res(KindError, '0, '0);
                cnt = cnt + 2'd1;
              end else begin
                acc_d = len32;
                if (len32 == '0) begin
                  slot[cnt[0]] = mk_res(KindEnd, '0, '0);
                  cnt = cnt + 2'd1;
                end else begin
                  rem_d = RemW'(len32);
                end
              end
            end
          end
        end
        ModeText: begin
          if (pcr_q && rx_byte_i == CharLf) begin
            pcr_d = 1'b0;
            slot[cnt[0]] = mk_res(KindEnd, '0, lc_q);
            cnt = cnt + 2'd1;
            lc_d = '0;
          end else begin
            // A held CR that is not followed by LF becomes an ordinary payload byte.
            if (pcr_q) begin
              slot[cnt[0]] = mk_res(KindPayload, CharCr, '0);
              cnt = cnt + 2'd1;
              if (lc_w != LineSat) lc_w = lc_w + 1'b1;
            end
            pcr_d = 1'b0;
            if (rx_byte_i == CharCr) begin
              pcr_d = 1'b1;
              lc_d  = lc_w;
            end else if (rx_byte_i == CharLf) begin
              slot[cnt[0]] = mk_res(KindEnd, '0, lc_w);
              cnt = cnt + 2'd1;
              lc_d = '0;
            end else begin
              slot[cnt[0]] = mk_res(KindPayload, rx_byte_i, '0);
              cnt = cnt + 2'd1;
              lc_d = (lc_w != LineSat) ? lc_w + 1'b1 : lc_w;
            end
          end
        end
        default: begin
          slot[cnt[0]] = mk_res(KindPayload, rx_byte_i, '0);
          cnt = cnt + 2'd1;
        end
      endcase
    end
  end

  assign push_o  = accept_i && (cnt != 2'd0);
  assign op_o.two = cnt[1];
  assign op_o.r0  = slot[0];
  assign op_o.r1  = slot[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q  <= '0;
      acc_q <= '0;
      rem_q <= '0;
      lc_q  <= '0;
      pcr_q <= 1'b0;
      err_q <= 1'b0;
    end else if (accept_i) begin
      hc_q  <= hc_d;
      acc_q <= acc_d;
      rem_q <= rem_d;
      lc_q  <= lc_d;
      pcr_q <= pcr_d;
      err_q <= err_d;
    end
  end

endmodule

### hw/rtl/rdf_fifo.sv
// Short queue of classified items between the front and back ends.
module rdf_fifo #(
  parameter int Depth = rdf_pkg::FifoDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  rdf_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output rdf_pkg::op_t op_o
);
  import rdf_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/rdf_back.sv
// Back end: expands each queued item into one or two results on the output register.
module rdf_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    op_valid_i,
  input  rdf_pkg::op_t            op_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              kind_o,
  output logic [7:0]              payload_byte_o,
  output logic [rdf_pkg::LenW-1:0] record_length_o,
  output logic                    last_o
);
  import rdf_pkg::*;

  logic out_valid_q, out_valid_d;
  logic sec_q, sec_d;
  res_t res_q, res_d, sec_res_q, sec_res_d;
  logic last_q, last_d;
  logic load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    pop_o       = 1'b0;
    out_valid_d = out_valid_q;
    sec_d       = sec_q;
    res_d       = res_q;
    sec_res_d   = sec_res_q;
    last_d      = last_q;
    if (load) begin
      if (sec_q) begin
        out_valid_d = 1'b1;
        res_d       = sec_res_q;
        last_d      = 1'b1;
        sec_d       = 1'b0;
      end else if (op_valid_i) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        res_d       = op_i.r0;
        last_d      = !op_i.two;
        sec_d       = op_i.two;
        sec_res_d   = op_i.r1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sec_q       <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    sec_res_q <= sec_res_d;
    last_q    <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = res_q.kind;
  assign payload_byte_o  = res_q.data;
  assign record_length_o = res_q.len;
  assign last_o          = last_q;

endmodule

### hw/rtl/record_deframer.sv
// Record deframer top level: configuration registers and the front, queue and back ends.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o   rx_byte_i
//   out      output     out_valid_o / out_stall_i kind_o, payload_byte_o, record_length_o, last_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle while the queue has room; each output cycle delivers one result.
// A byte that causes two results delivers them one after the other, and the queue of FifoDepth items
// absorbs that. A result passes through the queue and the output register after its byte.
// Reset clears the framing state, the queue and the output valid flag; configuration resets to zero.
// A stall on the output holds the result and fills the queue, which then stalls the input.
module record_deframer #(
  parameter int MaxLongRecord = rdf_pkg::MaxLongRecordDef,
  parameter int FifoDepth     = rdf_pkg::FifoDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output logic [7:0]               payload_byte_o,
  output logic [rdf_pkg::LenW-1:0] record_length_o,
  output logic                     last_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [15:0]              cfg_data_i
);
  import rdf_pkg::*;

  cfg_t cfg_q;
  logic accept, push, full, op_valid, pop;
  op_t  op_front, op_queue;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegMode:   cfg_q.mode    <= mode_e'(cfg_data_i[1:0]);
        RegMaxLen: cfg_q.max_len <= cfg_data_i;
        RegPolicy: cfg_q.policy  <= cfg_data_i[0];
        default:   cfg_q         <= cfg_q;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !in_stall_o;

  rdf_front #(
    .MaxLongRecord(MaxLongRecord)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .rx_byte_i(rx_byte_i),
    .push_o   (push),
    .op_o     (op_front)
  );

  rdf_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (op_front),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(op_valid),
    .op_o   (op_queue)
  );

  rdf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_i           (op_queue),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .record_length_o(record_length_o),
    .last_o         (last_o)
  );

endmodule

### hw/rtl/rdf_checker.sv
// Port-level checks on the record deframer and their binding to the top level.
`include "assert_macros.svh"

module rdf_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [1:0]               kind_o,
  input logic [7:0]               payload_byte_o,
  input logic [rdf_pkg::LenW-1:0] record_length_o,
  input logic                     last_o
);
  import rdf_pkg::*;

  // A stalled result stays offered with the same kind and length.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(kind_o) && $stable(record_length_o))

  `ASSERT_IMPLIES(a_byte_zero, clk_i, rst_ni, out_valid_o && kind_o != KindPayload,
                  payload_byte_o == '0)

  `ASSERT_IMPLIES(a_len_zero, clk_i, rst_ni, out_valid_o && kind_o != KindEnd,
                  record_length_o == '0)

  // A rejected header is always the only result of its byte.
  `ASSERT_IMPLIES(a_err_last, clk_i, rst_ni, out_valid_o && kind_o == KindError, last_o)

endmodule

bind record_deframer rdf_checker u_rdf_checker (.*);

### tb/tb_record_deframer.sv
`timescale 1ns / 100ps
// Self-checking testbench of record_deframer: directed and random byte streams in all modes.
module tb_record_deframer;
  import rdf_pkg::*;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    logic [LenW-1:0] len;
    logic            last;
  } deframed_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          kind_o;
  logic [7:0]          payload_byte_o;
  logic [LenW-1:0]     record_length_o;
  logic                last_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [15:0]         cfg_data_i  = '0;

  // Mirror of the configuration and the framing state of the block.
  mode_e               cfg_mode   = ModeHdr16;
  logic [15:0]         cfg_max    = '0;
  logic                cfg_policy = 1'b0;
  logic [2:0]          hdr_cnt    = '0;
  logic [31:0]         len_acc    = '0;
  logic [LenW-1:0]     remaining  = '0;
  logic [LenW-1:0]     line_len   = '0;
  logic                cr_held    = 1'b0;
  logic                err_stuck  = 1'b0;

  deframed_t           due_q[$];
  deframed_t           want;
  int                  mismatch_count = 0;
  int                  send_idle_pct  = 0;
  int                  stall_pct      = 0;
  logic [31:0]         planned_len    = '0;

  record_deframer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .record_length_o (record_length_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic deframed_t result_of(kind_e k, logic [7:0] d, logic [LenW-1:0] l);
    deframed_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    r.last = 1'b0;
    return r;
  endfunction

  // Works out the results of one accepted byte and queues them.
  task automatic deframe_byte(input logic [7:0] b);
    deframed_t   outs[$];
    logic [31:0] len;
    logic [2:0]  need;
    logic        done;
    done = 1'b0;
    if (!err_stuck) begin
      case (cfg_mode)
        ModeHdr16, ModeHdr32: begin
          need = (cfg_mode == ModeHdr32) ? 3'd4 : 3'd2;
          if (remaining != '0) begin
            outs.push_back(result_of(KindPayload, b, '0));
            remaining = remaining - 1'b1;
            if (remaining == '0) outs.push_back(result_of(KindEnd, '0, len_acc[LenW-1:0]));
          end else begin
            len_acc = {len_acc[23:0], b};
            hdr_cnt = hdr_cnt + 3'd1;
            if (hdr_cnt >= need) begin
              hdr_cnt = '0;
              if (cfg_mode == ModeHdr32) begin
                len = len_acc;
                err_stuck = (len > 32'(MaxLongRecordDef));
              end else begin
                len = {16'h0000, len_acc[15:0]};
                err_stuck = (cfg_max != '0) && (len > {16'h0000, cfg_max}) && !cfg_policy;
              end
              if (err_stuck) begin
                outs.push_back(result_of(KindError, '0, '0));
              end else begin
                len_acc = len;
                if (len == '0) outs.push_back(result_of(KindEnd, '0, '0));
                else remaining = len[LenW-1:0];
              end
            end
          end
        end
        ModeText: begin
          if (cr_held) begin
            cr_held = 1'b0;
            if (b == CharLf) begin
              outs.push_back(result_of(KindEnd, '0, line_len));
              line_len = '0;
              done = 1'b1;
            end else begin
              // A CR not followed by LF is payload after all.
              outs.push_back(result_of(KindPayload, CharCr, '0));
              if (line_len != LineSat) line_len = line_len + 1'b1;
            end
          end
          if (!done) begin
            if (b == CharCr) begin
              cr_held = 1'b1;
            end else if (b == CharLf) begin
              outs.push_back(result_of(KindEnd, '0, line_len));
              line_len = '0;
            end else begin
              outs.push_back(result_of(KindPayload, b, '0));
              if (line_len != LineSat) line_len = line_len + 1'b1;
            end
          end
        end
        default: begin
          outs.push_back(result_of(KindPayload, b, '0));
        end
      endcase
    end
    if (outs.size() != 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[k]) due_q.push_back(outs[k]);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
  endtask

  // Sends the low n bytes of v, most significant first.
  task automatic send_bytes(input int n, input logic [63:0] v);
    for (int k = n - 1; k >= 0; k--) send_byte(v[8*k +: 8]);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_q.size() != 0);
  endtask

  // Bytes that cause no result may still be in flight once the queue is empty.
  task automatic wait_idle();
    hold_until_drained();
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegMode:   cfg_mode   = mode_e'(value[1:0]);
      RegMaxLen: cfg_max    = value;
      RegPolicy: cfg_policy = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input mode_e m, input logic [15:0] max_len, input logic policy);
    write_reg(RegMode, 16'(m));
    write_reg(RegMaxLen, max_len);
    write_reg(RegPolicy, {15'h0000, policy});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_length_headers();
    set_config(ModeHdr16, 16'h0000, 1'b0);
    send_bytes(5, 64'h00_00_00_01_ff);
    wait_idle();
    // Over the limit but accepted by policy.
    set_config(ModeHdr16, 16'h0001, 1'b1);
    send_bytes(4, 64'h00_02_00_80);
    wait_idle();
    set_config(ModeHdr16, 16'h0001, 1'b0);
    send_bytes(3, 64'h00_01_7f);
    wait_idle();
    set_config(ModeHdr32, 16'hffff, 1'b0);
    send_bytes(5, 64'h00_00_00_01_c3);
    wait_idle();
  endtask

  task automatic test_text_lines();
    set_config(ModeText, 16'hffff, 1'b1);
    // CRLF line, then a lone CR before a byte, then a bare LF.
    send_bytes(6, 64'h61_0d_0a_0d_62_0a);
    wait_idle();
    set_config(ModePass, 16'hffff, 1'b1);
    send_bytes(2, 64'h00_ff);
    wait_idle();
  endtask

  // Framing state survives a change of mode.
  task automatic test_mode_switch();
    set_config(ModeHdr32, 16'h0000, 1'b0);
    send_byte(8'h00);
    wait_idle();
    set_config(ModeHdr16, 16'h0000, 1'b0);
    send_byte(8'h01);
    wait_idle();
    set_config(ModePass, 16'h0000, 1'b0);
    send_byte(8'h55);
    wait_idle();
    set_config(ModeHdr16, 16'h0000, 1'b0);
    send_byte(8'h66);
    wait_idle();
    set_config(ModeText, 16'h0000, 1'b0);
    send_byte(CharCr);
    wait_idle();
    set_config(ModePass, 16'h0000, 1'b0);
    send_byte(8'h77);
    wait_idle();
    set_config(ModeText, 16'h0000, 1'b0);
    send_byte(CharLf);
    wait_idle();
  endtask

  // Well-formed records with random payload; a phase never ends inside a header.
  task automatic run_random_phase(input int n_items, input int pause_at);
    logic [7:0] b;
    int         need;
    for (int i = 0; i < n_items || hdr_cnt != '0; i++) begin
      if (i == pause_at) hold_until_drained();
      case (cfg_mode)
        ModeHdr16, ModeHdr32: begin
          need = (cfg_mode == ModeHdr32) ? 4 : 2;
          if (remaining != '0) begin
            b = 8'($urandom);
          end else begin
            if (hdr_cnt == '0) begin
              case ($urandom_range(9))
                0:       planned_len = '0;
                1:       planned_len = $urandom_range(300, 17);
                default: planned_len = $urandom_range(16, 1);
              endcase
              if (cfg_mode == ModeHdr16 && cfg_max != '0 && !cfg_policy &&
                  planned_len > {16'h0000, cfg_max}) begin
                planned_len = {16'h0000, cfg_max};
              end
            end
            b = 8'(planned_len >> (8 * (need - 1 - int'(hdr_cnt))));
          end
        end
        ModeText: begin
          case ($urandom_range(19))
            0, 1:    b = CharLf;
            2, 3:    b = CharCr;
            default: b = 8'($urandom);
          endcase
        end
        default: b = 8'($urandom);
      endcase
      send_byte(b);
    end
  endtask

  task automatic test_random_records();
    mode_e       m;
    logic [15:0] max_len;
    int          pause_at;
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      m = (p < 4) ? mode_e'(p) : mode_e'($urandom_range(3));
      case ($urandom_range(3))
        0:       max_len = 16'h0000;
        1:       max_len = 16'hffff;
        2:       max_len = 16'($urandom_range(40, 1));
        default: max_len = 16'($urandom);
      endcase
      if (p == 0) max_len = 16'hffff;
      set_config(m, max_len, 1'($urandom));
      pause_at = (p == 2 || $urandom_range(3) == 0) ? $urandom_range(119, 1) : -1;
      run_random_phase(120, pause_at);
    end
  endtask

  // Only one error fits in a run, since it holds until reset.
  task automatic test_sticky_error();
    logic [31:0] bad_len;
    wait_idle();
    send_idle_pct = 18;
    stall_pct     = 18;
    if ($urandom_range(1) == 0) begin
      set_config(ModeHdr16, 16'($urandom_range(65534, 1)), 1'b0);
      while (remaining != '0) send_byte(8'($urandom));
      bad_len = $urandom_range(65535, {16'h0000, cfg_max} + 32'd1);
      send_bytes(2, {32'h0, bad_len});
    end else begin
      set_config(ModeHdr32, 16'h0000, 1'b0);
      while (remaining != '0) send_byte(8'($urandom));
      bad_len = $urandom_range(32'hffffffff, 32'(MaxLongRecordDef) + 32'd1);
      send_bytes(4, {32'h0, bad_len});
    end
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      set_config(mode_e'(k), 16'h0000, 1'b1);
      send_bytes(4, {32'h0, 32'($urandom)});
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_q.size() == 0) begin
        $error("unexpected result: kind %0d, byte 0x%02h, length %0d",
               kind_o, payload_byte_o, record_length_o);
        mismatch_count++;
      end else begin
        want = due_q.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          mismatch_count++;
        end
        if (payload_byte_o !== want.data) begin
          $error("payload_byte: expected 0x%02h, got 0x%02h", want.data, payload_byte_o);
          mismatch_count++;
        end
        if (record_length_o !== want.len) begin
          $error("record_length: expected %0d, got %0d", want.len, record_length_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_length_headers();
    test_text_lines();
    test_mode_switch();
    test_random_records();
    test_sticky_error();
    hold_until_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && due_q.size() == 0) begin
      $display("tb_record_deframer passed");
    end else begin
      $display("tb_record_deframer failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_record_deframer failed");
    $finish;
  end

endmodule
